>>> rtl/core/bdq_pkg.sv
// shared types, codes and constants for the bounded deque
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int ACTION_W      = 3;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;

    typedef logic [ACTION_W-1:0]        action_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic [STATUS_W-1:0]        status_t;

    localparam action_t ACT_PUSH_FRONT = 3'd0;
    localparam action_t ACT_PUSH_BACK  = 3'd1;
    localparam action_t ACT_POP_FRONT  = 3'd2;
    localparam action_t ACT_POP_BACK   = 3'd3;
    localparam action_t ACT_LIST_FWD   = 3'd4;
    localparam action_t ACT_LIST_BWD   = 3'd5;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic do_push;
        logic do_pop;
        logic at_front;
        logic list_empty;
        logic list_start;
        logic list_read;
        logic list_load;
    } bdq_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic out_free;
        logic list_last;
    } bdq_stat_t;

endpackage

>>> rtl/core/bdq_ram.sv
// generic single-write, single-read ram with registered read data
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/bdq_ctrl.sv
// controller: input handshake, action decode and listing sequencer
module bdq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bdq_pkg::action_t   action,
    input  bdq_pkg::bdq_stat_t stat,
    output bdq_pkg::bdq_cmd_t  cmd
);
    import bdq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LRD  = 2'd1;
    localparam logic [1:0] S_LLD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action) inside
                        ACT_PUSH_FRONT, ACT_PUSH_BACK:
                        begin
                            cmd.do_push  = 1'b1;
                            cmd.at_front = (action == ACT_PUSH_FRONT);
                        end
                        ACT_POP_FRONT, ACT_POP_BACK:
                        begin
                            cmd.do_pop   = 1'b1;
                            cmd.at_front = (action == ACT_POP_FRONT);
                        end
                        ACT_LIST_FWD, ACT_LIST_BWD:
                        begin
                            cmd.at_front = (action == ACT_LIST_FWD);
                            if (stat.empty)
                            begin
                                cmd.list_empty = 1'b1;
                            end
                            else
                            begin
                                cmd.list_start = 1'b1;
                                state_next     = S_LRD;
                            end
                        end
                        default:
                        begin
                            // unused codes are taken and dropped
                        end
                    endcase
                end
            end
            S_LRD:
            begin
                cmd.list_read = 1'b1;
                state_next    = S_LLD;
            end
            S_LLD:
            begin
                // read data holds until the output slot frees up
                if (stat.out_free)
                begin
                    cmd.list_load = 1'b1;
                    state_next    = stat.list_last ? S_IDLE : S_LRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/bdq_dp.sv
// datapath: front pointer, count, entry store, list index and output register
module bdq_dp #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bdq_pkg::value_t    value,
    input  bdq_pkg::bdq_cmd_t  cmd,
    output bdq_pkg::bdq_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output bdq_pkg::value_t    entry,
    output bdq_pkg::status_t   status,
    output logic               last
);
    import bdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] TOP_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          dir_back_reg, dir_back_next;
    logic          out_valid_reg, out_valid_next;
    value_t        entry_reg, entry_next;
    status_t       status_reg, status_next;
    logic          last_reg, last_next;

    logic          empty;
    logic          full;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [AW:0]   back_sum;
    logic [AW-1:0] back_slot;
    logic [AW-1:0] list_off;
    logic [AW:0]   list_sum;
    logic [AW-1:0] list_slot;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [VALUE_W-1:0] ram_rdata;
    logic          load;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_CNT);

    // circular pointer arithmetic, every sum stays below twice the depth
    assign front_dec = (front_reg == '0) ? TOP_PTR : front_reg - AW'(1);
    assign front_inc = (front_reg == TOP_PTR) ? '0 : front_reg + AW'(1);
    assign back_sum  = {1'b0, front_reg} + (AW+1)'(count_reg);
    assign back_slot = (back_sum >= DEPTH_W) ? AW'(back_sum - DEPTH_W) : back_sum[AW-1:0];

    assign list_off  = dir_back_reg ? AW'(count_reg - CW'(1) - CW'(idx_reg)) : idx_reg;
    assign list_sum  = {1'b0, front_reg} + {1'b0, list_off};
    assign list_slot = (list_sum >= DEPTH_W) ? AW'(list_sum - DEPTH_W) : list_sum[AW-1:0];

    assign ram_we    = cmd.do_push && !full;
    assign ram_waddr = cmd.at_front ? front_dec : back_slot;

    bdq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .re    (cmd.list_read),
        .raddr (list_slot),
        .rdata (ram_rdata)
    );

    assign stat.empty     = empty;
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.list_last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    assign load = cmd.do_push || cmd.do_pop || cmd.list_empty || cmd.list_load;

    always_comb
    begin
        front_next    = front_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        dir_back_next = dir_back_reg;
        entry_next    = entry_reg;
        status_next   = status_reg;
        last_next     = last_reg;

        if (cmd.do_push)
        begin
            entry_next = '0;
            last_next  = 1'b1;
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_DONE;
                count_next  = count_reg + CW'(1);
                if (cmd.at_front)
                begin
                    front_next = front_dec;
                end
            end
        end

        if (cmd.do_pop)
        begin
            entry_next = '0;
            last_next  = 1'b1;
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next = ST_DONE;
                count_next  = count_reg - CW'(1);
                if (cmd.at_front)
                begin
                    front_next = front_inc;
                end
            end
        end

        if (cmd.list_empty)
        begin
            entry_next  = '0;
            status_next = ST_EMPTY;
            last_next   = 1'b1;
        end

        if (cmd.list_start)
        begin
            idx_next      = '0;
            dir_back_next = !cmd.at_front;
        end

        if (cmd.list_load)
        begin
            entry_next  = value_t'(ram_rdata);
            status_next = ST_DONE;
            last_next   = stat.list_last;
            idx_next    = idx_reg + AW'(1);
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        dir_back_reg <= dir_back_next;
        entry_reg    <= entry_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign entry     = entry_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

>>> rtl/core/bounded_deque_with_listing.sv
// top level of the bounded deque: controller plus datapath
// push, pop and empty listing: one beat in, one result beat out in the cycle after acceptance.
// a listing of n entries gives n beats, each a store read, then the output register
// load once the output slot is free; in_ready stays low until the last beat is loaded.
// a new beat is taken in the cycle the pending result leaves the output register.
// reset clears front pointer, count and output valid; the entry store is not cleared.
module bounded_deque_with_listing #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bdq_pkg::action_t action,
    input  bdq_pkg::value_t  value,
    output logic             out_valid,
    input  logic             out_ready,
    output bdq_pkg::value_t  entry,
    output bdq_pkg::status_t status,
    output logic             last
);
    import bdq_pkg::*;

    bdq_cmd_t  cmd;
    bdq_stat_t stat;

    bdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .stat     (stat),
        .cmd      (cmd)
    );

    bdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .entry     (entry),
        .status    (status),
        .last      (last)
    );

endmodule

>>> bench/tb.sv
// testbench for the bounded deque: directed and random action beats checked against a predictor
module tb;
    import bdq_pkg::*;

    localparam int DEPTH    = DEPTH_DEFAULT;
    localparam int IDLE_PCT = 32;

    // codes outside the defined actions, the block drops them
    localparam action_t ACT_SPARE_LO = 3'd6;
    localparam action_t ACT_SPARE_HI = 3'd7;

    typedef struct {
        value_t  entry;
        status_t status;
        logic    last;
    } deque_result_t;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    action_t action;
    value_t  value;
    logic    out_valid;
    logic    out_ready;
    value_t  entry;
    status_t status;
    logic    last;

    // predictor copy of the deque
    value_t        deque_store [DEPTH];
    logic [5:0]    head_ptr;
    logic [6:0]    fill_count;
    deque_result_t awaited_results [$];
    int            mismatches;
    bit            steady;

    bounded_deque_with_listing u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .entry     (entry),
        .status    (status),
        .last      (last)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #4_000_000;
        $display("tb failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void await_result(value_t e, status_t s, logic l);
        deque_result_t r;
        r.entry  = e;
        r.status = s;
        r.last   = l;
        awaited_results.push_back(r);
    endfunction

    // apply one accepted action to the deque copy and queue the beats it gives
    function automatic void predict_action(action_t act, value_t val);
        logic [5:0] slot;
        logic [6:0] offset;
        int         i;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (fill_count == DEPTH)
                begin
                    await_result('0, ST_FULL, 1'b1);
                end
                else
                begin
                    if (act == ACT_PUSH_FRONT)
                    begin
                        head_ptr = head_ptr - 6'd1;
                        slot     = head_ptr;
                    end
                    else
                    begin
                        slot = head_ptr + fill_count[5:0];
                    end
                    deque_store[slot] = val;
                    fill_count++;
                    await_result('0, ST_DONE, 1'b1);
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (fill_count == 0)
                begin
                    await_result('0, ST_EMPTY, 1'b1);
                end
                else
                begin
                    if (act == ACT_POP_FRONT)
                        head_ptr = head_ptr + 6'd1;
                    fill_count--;
                    await_result('0, ST_DONE, 1'b1);
                end
            end
            ACT_LIST_FWD, ACT_LIST_BWD:
            begin
                if (fill_count == 0)
                begin
                    await_result('0, ST_EMPTY, 1'b1);
                end
                else
                begin
                    for (i = 0; i < fill_count; i++)
                    begin
                        offset = (act == ACT_LIST_FWD) ? 7'(i) : 7'(fill_count - 1 - i);
                        slot   = head_ptr + offset[5:0];
                        await_result(deque_store[slot], ST_DONE, i == fill_count - 1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // one input beat: optional idle cycles, then hold valid until accepted
    task automatic send_action(action_t act, value_t val);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_action(act, val);
    endtask

    function automatic value_t any_value();
        return value_t'($urandom);
    endfunction

    function automatic action_t any_pop();
        return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
    endfunction

    function automatic action_t any_push();
        return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    endfunction

    function automatic action_t any_listing();
        return $urandom_range(1) ? ACT_LIST_BWD : ACT_LIST_FWD;
    endfunction

    always @(posedge clk)
    begin : result_check
        deque_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing awaited, entry %0d status %0d",
                                          entry, status));
            end
            else
            begin
                want = awaited_results.pop_front();
                if (entry !== want.entry)
                    report_mismatch($sformatf("entry %0d, want %0d", entry, want.entry));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", status, want.status));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", last, want.last));
            end
        end
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic test_empty_queue();
        send_action(ACT_LIST_FWD, any_value());
        send_action(ACT_LIST_BWD, -1);
        send_action(ACT_POP_FRONT, any_value());
        send_action(ACT_POP_BACK, any_value());
    endtask

    task automatic test_push_pop();
        send_action(ACT_PUSH_FRONT, 32'sh8000_0000);
        send_action(ACT_PUSH_BACK, 32'sh7fff_ffff);
        send_action(ACT_PUSH_FRONT, -1);
        send_action(ACT_PUSH_BACK, 0);
        send_action(ACT_PUSH_BACK, 1);
        send_action(ACT_LIST_FWD, any_value());
        send_action(ACT_LIST_BWD, any_value());
        send_action(ACT_POP_FRONT, any_value());
        send_action(ACT_POP_BACK, any_value());
        send_action(ACT_LIST_FWD, 32'sh5555_5555);
        send_action(ACT_POP_FRONT, 32'shaaaa_aaaa);
        send_action(ACT_POP_BACK, any_value());
        send_action(ACT_POP_FRONT, any_value());
        send_action(ACT_POP_BACK, any_value());
        send_action(ACT_LIST_BWD, any_value());
    endtask

    task automatic test_spare_actions();
        send_action(ACT_PUSH_BACK, any_value());
        send_action(ACT_SPARE_LO, any_value());
        send_action(ACT_SPARE_HI, -1);
        send_action(ACT_LIST_FWD, any_value());
    endtask

    // mostly pushes until the store is full, then pushes that must be dropped and a listing each way
    task automatic test_fill_to_full();
        int pick;
        steady = 1'b1;
        while (fill_count < DEPTH)
        begin
            pick = $urandom_range(99);
            if (pick < 46)
                send_action(ACT_PUSH_FRONT, any_value());
            else if (pick < 92)
                send_action(ACT_PUSH_BACK, any_value());
            else if (pick < 96)
                send_action(any_pop(), any_value());
            else
                send_action(any_listing(), any_value());
        end
        steady = 1'b0;
        send_action(ACT_PUSH_FRONT, any_value());
        send_action(ACT_PUSH_BACK, any_value());
        send_action(ACT_LIST_FWD, any_value());
        send_action(ACT_LIST_BWD, any_value());
    endtask

    task automatic test_drain();
        int pick;
        while (fill_count > 0)
        begin
            pick = $urandom_range(99);
            if (pick < 90)
                send_action(any_pop(), any_value());
            else if (pick < 93)
                send_action(any_push(), any_value());
            else
                send_action(any_listing(), any_value());
        end
        send_action(ACT_POP_FRONT, any_value());
        send_action(ACT_POP_BACK, any_value());
    endtask

    task automatic test_random_mix();
        int n;
        for (n = 0; n < 15; n++)
            send_action(action_t'($urandom_range(7)), any_value());
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_PUSH_FRONT;
        value      = '0;
        out_ready  = 1'b0;
        head_ptr   = '0;
        fill_count = '0;
        mismatches = 0;
        steady     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_push_pop();
        test_spare_actions();
        test_fill_to_full();
        test_drain();
        test_random_mix();
        in_valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
